>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// check that a property holds at every rising edge out of reset
`define QPSK_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// check that a condition never holds out of reset
`define QPSK_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define QPSK_ASSERT(name, clk, rst, prop)
`define QPSK_NEVER(name, clk, rst, cond)
`endif

`endif

>>> design/qpsk_psm_pkg.sv
// ----------------------------------------------------------------------------
// qpsk_psm_pkg
// Types, widths and codes shared by the QPSK pulse-shaped modulator.
// ----------------------------------------------------------------------------
package qpsk_psm_pkg;

  // default geometry of the polyphase filter
  localparam int SAMPLES_PER_SYMBOL = 20;
  localparam int SYMBOL_SPAN        = 6;

  // fixed field widths
  localparam int COEF_W    = 16;
  localparam int CIDX_W    = 7;
  localparam int OUT_W     = 16;
  localparam int AMP_W     = 18;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;
  localparam int CFG_IDX_W = 1;

  // register reset values
  localparam logic [AMP_W-1:0]  AMP_RESET  = AMP_W'(160000);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 1'b1;

  // item operations
  localparam logic OP_SYMBOL    = 1'b0;
  localparam logic OP_COEF_WR   = 1'b1;

  // carrier phases: I, -Q, -I, Q
  localparam logic [1:0] CAR_I  = 2'd0;
  localparam logic [1:0] CAR_NQ = 2'd1;
  localparam logic [1:0] CAR_NI = 2'd2;
  localparam logic [1:0] CAR_Q  = 2'd3;

  typedef struct packed {
    logic                     operation;
    logic [1:0]               symbol;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample;
    logic                    last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic coef_wr;
    logic sym_push;
    logic issue;
    logic last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic adv;
    logic busy;
  } dp_status_t;

endpackage

>>> design/qpsk_psm_ctrl.sv
// ----------------------------------------------------------------------------
// qpsk_psm_ctrl
// Sequencer: takes items, steps the sample phase and waits for the pipe to empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qpsk_psm_ctrl #(
  parameter int SPS = qpsk_psm_pkg::SAMPLES_PER_SYMBOL
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  qpsk_psm_pkg::dp_status_t     status,
  output qpsk_psm_pkg::dp_cmd_t        cmd,
  output logic [$clog2(SPS)-1:0]       phase
);
  import qpsk_psm_pkg::*;

  localparam int PW = $clog2(SPS);

  typedef enum logic [2:0] {
    IDLE  = 3'b001,
    RUN   = 3'b010,
    DRAIN = 3'b100
  } state_t;

  state_t        state, state_next;
  logic [PW-1:0] phase_next;
  logic          accept;
  logic          last_phase;

  assign in_ready   = (state == IDLE);
  assign accept     = in_valid && in_ready;
  assign last_phase = (phase == PW'(SPS - 1));

  // commands to the datapath
  always_comb begin
    cmd.coef_wr  = accept && (operation == OP_COEF_WR);
    cmd.sym_push = accept && (operation == OP_SYMBOL);
    cmd.issue    = (state == RUN) && status.adv;
    cmd.last     = last_phase;
  end

  // next state and phase
  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      IDLE: begin
        if (cmd.sym_push) begin
          state_next = RUN;
          phase_next = '0;
        end
      end
      RUN: begin
        if (status.adv) begin
          if (last_phase) begin
            state_next = DRAIN;
          end else begin
            phase_next = phase + PW'(1);
          end
        end
      end
      DRAIN: begin
        if (!status.busy) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      phase <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  `QPSK_ASSERT(a_push_starts_run, clk, rst, cmd.sym_push |=> (state == RUN) && (phase == '0))
  `QPSK_ASSERT(a_last_goes_drain, clk, rst, (cmd.issue && cmd.last) |=> (state == DRAIN))
  `QPSK_NEVER(a_no_wr_when_busy, clk, rst, cmd.coef_wr && (state != IDLE))

endmodule

>>> design/qpsk_psm_dp.sv
// ----------------------------------------------------------------------------
// qpsk_psm_dp
// Coefficient banks, symbol history, tap sum, carrier mix, scale and saturate.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qpsk_psm_dp #(
  parameter int SPS  = qpsk_psm_pkg::SAMPLES_PER_SYMBOL,
  parameter int SPAN = qpsk_psm_pkg::SYMBOL_SPAN
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  qpsk_psm_pkg::in_item_t                  in_data,
  input  qpsk_psm_pkg::dp_cmd_t                   cmd,
  input  logic [$clog2(SPS)-1:0]                  phase,
  output qpsk_psm_pkg::dp_status_t                status,
  input  logic                                    cfg_we,
  input  logic [qpsk_psm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qpsk_psm_pkg::AMP_W-1:0]          cfg_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output qpsk_psm_pkg::out_item_t                 out_data
);
  import qpsk_psm_pkg::*;

  localparam int PW      = $clog2(SPS);
  localparam int TW      = $clog2(SPAN);
  localparam int MW      = COEF_W + $clog2(SPAN);
  localparam int SW      = MW + 1;
  localparam int SCALE_W = AMP_W + GAIN_W;
  localparam int PRW     = MW + SCALE_W;
  localparam int SH      = COEF_W - 1 + GAIN_FRAC;
  localparam int NUM     = SPS * SPAN;
  localparam int NUM_W   = $clog2(NUM + 1);
  localparam int XW      = (CIDX_W > NUM_W) ? CIDX_W : NUM_W;

  // configuration
  logic [AMP_W-1:0]   amplitude;
  logic [GAIN_W-1:0]  gain;
  logic [SCALE_W-1:0] scale;

  // symbol history
  logic [1:0] hist_sym [SPAN];
  logic       hist_vld [SPAN];

  // write address decode
  logic [XW-1:0] idx_ext;
  logic          wr_in_range;
  logic [TW-1:0] wr_tap;
  logic [PW-1:0] wr_phase;

  // pipeline registers
  logic                     v1, last1;
  logic [1:0]               car1;
  logic signed [COEF_W-1:0] rd [SPAN];
  logic                     v2, last2;
  logic signed [SW-1:0]     sel2;
  logic                     v3, last3, neg3;
  logic [PRW-1:0]           prod3;

  logic                 adv;
  logic [1:0]           car_issue;
  logic signed [SW-1:0] si, sq, sel;
  logic                 neg;
  logic [MW-1:0]        mag;
  logic [PRW-1:0]       shifted, lim, mag_c;

  assign adv         = !out_valid || out_ready;
  assign status.adv  = adv;
  assign status.busy = v1 || v2 || v3 || out_valid;

  // hold the configuration registers and the combined scale
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= AMP_RESET;
      gain      <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AMPLITUDE: amplitude <= cfg_data;
        REG_GAIN:      gain      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scale <= SCALE_W'(amplitude) * SCALE_W'(gain);
  end

  // split the coefficient address into tap and phase
  always_comb begin
    idx_ext     = XW'(in_data.coef_index);
    wr_in_range = (idx_ext < XW'(NUM));
    wr_tap      = '0;
    wr_phase    = PW'(idx_ext);
    for (int t = 1; t < SPAN; t++) begin
      if (idx_ext >= XW'(t * SPS)) begin
        wr_tap   = TW'(t);
        wr_phase = PW'(idx_ext - XW'(t * SPS));
      end
    end
  end

  // shift the symbol history on each new symbol
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < SPAN; t++) begin
        hist_vld[t] <= 1'b0;
      end
    end else if (cmd.sym_push) begin
      hist_vld[0] <= 1'b1;
      for (int t = 1; t < SPAN; t++) begin
        hist_vld[t] <= hist_vld[t-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sym_push) begin
      hist_sym[0] <= in_data.symbol;
      for (int t = 1; t < SPAN; t++) begin
        hist_sym[t] <= hist_sym[t-1];
      end
    end
  end

  // one coefficient bank per tap, all read at the same phase
  for (genvar g = 0; g < SPAN; g++) begin : g_bank
    logic [COEF_W-1:0] bank [SPS];

    always_ff @(posedge clk) begin
      if (cmd.coef_wr && wr_in_range && (wr_tap == TW'(g))) begin
        bank[wr_phase] <= in_data.coef_value;
      end
      if (cmd.issue) begin
        rd[g] <= bank[phase];
      end
    end
  end

  // carrier phase of the issued sample
  assign car_issue = (phase == PW'(SPS - 1)) ? CAR_I : (phase[1:0] + 2'd1);

  // stage 1: read
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      last1 <= cmd.last;
      car1  <= car_issue;
    end
  end

  // sum the taps per branch and mix with the carrier
  always_comb begin
    si = '0;
    sq = '0;
    for (int t = 0; t < SPAN; t++) begin
      if (hist_vld[t]) begin
        si = hist_sym[t][0] ? (si - SW'(rd[t])) : (si + SW'(rd[t]));
        sq = hist_sym[t][1] ? (sq - SW'(rd[t])) : (sq + SW'(rd[t]));
      end
    end
    case (car1)
      CAR_I:   sel = si;
      CAR_NQ:  sel = -sq;
      CAR_NI:  sel = -si;
      CAR_Q:   sel = sq;
      default: sel = si;
    endcase
  end

  // stage 2: mixed sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel2  <= sel;
      last2 <= last1;
    end
  end

  // stage 3: magnitude times amplitude and gain
  assign neg = sel2[SW-1];
  assign mag = neg ? MW'(-sel2) : MW'(sel2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod3 <= PRW'(mag) * PRW'(scale);
      neg3  <= neg;
      last3 <= last2;
    end
  end

  // truncate, saturate and restore the sign
  always_comb begin
    shifted = prod3 >> SH;
    lim     = neg3 ? PRW'(1 << (OUT_W - 1)) : PRW'((1 << (OUT_W - 1)) - 1);
    mag_c   = (shifted > lim) ? lim : shifted;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.sample <= neg3 ? -signed'(mag_c[OUT_W-1:0]) : signed'(mag_c[OUT_W-1:0]);
      out_data.last   <= last3;
    end
  end

  `QPSK_NEVER(a_push_while_busy, clk, rst, cmd.sym_push && status.busy)
  `QPSK_NEVER(a_wr_while_busy, clk, rst, cmd.coef_wr && status.busy)
  `QPSK_NEVER(a_hist_contiguous, clk, rst, hist_vld[1] && !hist_vld[0])

endmodule

>>> design/qpsk_psm_top.sv
// ----------------------------------------------------------------------------
// qpsk_pulse_shaped_modulator_core
// QPSK modulator with polyphase pulse-shaping filter and quarter-rate carrier.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one beat is either a symbol or a
//   coefficient write. A coefficient write yields nothing.
//   A symbol yields SAMPLES_PER_SYMBOL beats on the out channel
//   (out_valid/out_ready/out_data), the last one flagged by last.
//   Load all coefficients before sending symbols.
//   cfg port (cfg_we/cfg_index/cfg_data): amplitude at index 0, gain at
//   index 1; write them only while no symbol is in flight (not enforced).
// Timing:
//   After a symbol is taken, its samples leave one a cycle while the receiver
//   does not stall, through a four-stage pipe (bank read, tap sum, multiply,
//   clamp). A new symbol is taken only after the previous one is done:
//   in_ready is low from after acceptance until the pipe has drained. All
//   taps of one sample are read together from one bank per tap, which sets
//   the one-sample-a-cycle rate.
//   A receiver stall freezes the whole pipe; nothing is lost.
// Reset: clears the symbol history and restores amplitude and gain defaults;
//   coefficient banks keep their contents and must be reloaded.
// ----------------------------------------------------------------------------
module qpsk_pulse_shaped_modulator_core #(
  parameter int SAMPLES_PER_SYMBOL = qpsk_psm_pkg::SAMPLES_PER_SYMBOL,
  parameter int SYMBOL_SPAN        = qpsk_psm_pkg::SYMBOL_SPAN
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  qpsk_psm_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output qpsk_psm_pkg::out_item_t            out_data,
  input  logic                               cfg_we,
  input  logic [qpsk_psm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qpsk_psm_pkg::AMP_W-1:0]     cfg_data
);
  import qpsk_psm_pkg::*;

  dp_cmd_t                           cmd;
  dp_status_t                        status;
  logic [$clog2(SAMPLES_PER_SYMBOL)-1:0] phase;

  qpsk_psm_ctrl #(
    .SPS (SAMPLES_PER_SYMBOL)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (in_data.operation),
    .status    (status),
    .cmd       (cmd),
    .phase     (phase)
  );

  qpsk_psm_dp #(
    .SPS  (SAMPLES_PER_SYMBOL),
    .SPAN (SYMBOL_SPAN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .phase     (phase),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
